@@ rtl/tcw_pkg.sv @@
// Shared constants, codes and controller/datapath types of the text console writer.
package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int COL_W   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;
	localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;

	// Field widths of the stream beats
	localparam int CMD_W   = 2;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int COLF_W  = 7;
	localparam int ROWF_W  = 5;
	localparam int WORD_W  = 16;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [0:0] REG_BLANK_ATTR = 1'b0;

	// Character and attribute codes
	localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'h0A;
	localparam logic [CHAR_W-1:0] BLANK_CHAR       = 8'h20;
	localparam logic [ATTR_W-1:0] LIGHT_GRAY_ATTR  = 8'h07;
	localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h0F;
	localparam logic [WORD_W-1:0] CLEAR_CELL       = {LIGHT_GRAY_ATTR, BLANK_CHAR};

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT       = 2'd0,
		CMD_BACKSPACE = 2'd1,
		CMD_CLEAR     = 2'd2,
		CMD_READ      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_FILL,
		ST_COPY,
		ST_DRAIN,
		ST_BLANK
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch_item;
		logic exec;
		logic fill_wr;
		logic copy_rd;
		logic blank_wr;
		logic sweep_clr;
		logic sweep_blank;
		logic sweep_step;
		logic out_load;
		logic word_sel;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		cmd_t item_cmd;
		logic wrap_scroll;
		logic read_hit;
		logic sweep_last;
		logic copy_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

@@ rtl/text_console_writer.sv @@
// Top level of the text console writer: stream ports, APB register, controller and datapath.
//
// Usage:
//  - Commands enter on the s_ stream; each accepted beat yields exactly one
//    result beat on the m_ stream, in order.
//  - Commands: put character (newline moves to the start of the next row),
//    backspace, clear screen, read cell. Every result carries the cursor
//    after the command, the read cell word (zero for non-read commands) and
//    a flag telling whether the screen scrolled.
//  - Sequencing: a put (without a scroll) or backspace is latched on accept
//    and its result is loaded in ST_EXEC; an in-range read adds ST_RDWAIT
//    for one registered store read. A clear sweeps the whole store, one
//    cell per cycle; a scroll copies the store up one row and blanks the
//    bottom row, one cell per cycle, paced by the single store write port.
//  - A new command is taken only in ST_IDLE, once the previous one has executed.
//  - Reset: the cursor homes and the blank attribute returns to 0x0F; the store
//    is then filled with light-gray blanks while s_tready stays low. APB writes
//    are taken at any time.
//  - A stalled receiver holds the result register; a new command is still
//    taken in the cycle the waiting result leaves.
module text_console_writer (
	input  logic                               clk,
	input  logic                               arst_n,
	// Command stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [1:0] cmd, [9:2] char_code, [17:10] color, [28:18] cell_index, [31:29] zero
	input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_tdata,
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [10:0] cursor_position, [17:11] cursor_column, [22:18] cursor_row,
	// [38:23] cell_word, [39] scrolled
	output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// Configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tcw_pkg::APB_AW-1:0]         paddr,
	input  logic [tcw_pkg::APB_DW-1:0]         pwdata,
	output logic [tcw_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);
	import tcw_pkg::*;

	ctrl_cmd_t         cmd;
	ctrl_sts_t         sts;
	logic [ATTR_W-1:0] blank_attr_q;
	logic              reg_hit;

	logic [POS_W-1:0]  cursor_position;
	logic [COLF_W-1:0] cursor_column;
	logic [ROWF_W-1:0] cursor_row;
	logic [WORD_W-1:0] cell_word;
	logic              scrolled;

	// APB: no wait states; register index is the word address
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_BLANK_ATTR);
	assign prdata  = reg_hit ? APB_DW'(blank_attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= BLANK_ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			blank_attr_q <= pwdata[ATTR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Unpack the command beat straight into the datapath
	tcw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_cmd          (s_tdata[1:0]),
		.in_char_code    (s_tdata[9:2]),
		.in_color        (s_tdata[17:10]),
		.in_cell_index   (s_tdata[28:18]),
		.blank_attr      (blank_attr_q),
		.m_tready        (m_tready),
		.out_valid       (m_tvalid),
		.cursor_position (cursor_position),
		.cursor_column   (cursor_column),
		.cursor_row      (cursor_row),
		.cell_word       (cell_word),
		.scrolled        (scrolled)
	);

	// Pack the result beat, first field lowest
	assign m_tdata = {scrolled, cell_word, cursor_row, cursor_column, cursor_position};

endmodule

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/tcw_ctrl.sv @@
// Sequencing state machine of the text console writer.
module tcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  tcw_pkg::ctrl_sts_t sts,
	output tcw_pkg::ctrl_cmd_t cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid && sts.out_free) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (sts.item_cmd)
					CMD_PUT:       state_d = sts.wrap_scroll ? ST_COPY : ST_IDLE;
					CMD_BACKSPACE: state_d = ST_IDLE;
					CMD_CLEAR:     state_d = ST_FILL;
					CMD_READ:      state_d = sts.read_hit ? ST_RDWAIT : ST_IDLE;
					default:       state_d = ST_IDLE;
				endcase
			end
			ST_RDWAIT: state_d = ST_IDLE;
			ST_FILL: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_COPY: begin
				if (sts.copy_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_BLANK;
			ST_BLANK: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.fill_wr    = 1'b1;
				cmd.sweep_step = 1'b1;
			end
			ST_IDLE: begin
				s_tready       = sts.out_free;
				cmd.latch_item = s_tvalid && sts.out_free;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				unique case (sts.item_cmd)
					CMD_PUT: begin
						cmd.sweep_clr = sts.wrap_scroll;
						cmd.out_load  = !sts.wrap_scroll;
					end
					CMD_BACKSPACE: cmd.out_load  = 1'b1;
					CMD_CLEAR:     cmd.sweep_clr = 1'b1;
					CMD_READ:      cmd.out_load  = !sts.read_hit;
					default:       cmd.out_load  = 1'b1;
				endcase
			end
			ST_RDWAIT: begin
				cmd.out_load = 1'b1;
				cmd.word_sel = 1'b1;
			end
			ST_FILL: begin
				cmd.fill_wr    = 1'b1;
				cmd.sweep_step = 1'b1;
				cmd.out_load   = sts.sweep_last;
			end
			ST_COPY: begin
				cmd.copy_rd    = 1'b1;
				cmd.sweep_step = 1'b1;
			end
			ST_DRAIN: cmd.sweep_blank = 1'b1;
			ST_BLANK: begin
				cmd.blank_wr   = 1'b1;
				cmd.sweep_step = 1'b1;
				cmd.out_load   = sts.sweep_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

@@ rtl/tcw_dp.sv @@
// Datapath: cursor, screen store, sweep counter and result register.
module tcw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcw_pkg::ctrl_cmd_t            cmd,
	output tcw_pkg::ctrl_sts_t            sts,
	input  logic [tcw_pkg::CMD_W-1:0]     in_cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
	input  logic [tcw_pkg::ATTR_W-1:0]    in_color,
	input  logic [tcw_pkg::IDX_W-1:0]     in_cell_index,
	input  logic [tcw_pkg::ATTR_W-1:0]    blank_attr,
	input  logic                          m_tready,
	output logic                          out_valid,
	output logic [tcw_pkg::POS_W-1:0]     cursor_position,
	output logic [tcw_pkg::COLF_W-1:0]    cursor_column,
	output logic [tcw_pkg::ROWF_W-1:0]    cursor_row,
	output logic [tcw_pkg::WORD_W-1:0]    cell_word,
	output logic                          scrolled
);
	import tcw_pkg::*;

	// Latched command
	cmd_t              item_cmd_q;
	logic [CHAR_W-1:0] item_char_q;
	logic [ATTR_W-1:0] item_color_q;
	logic [IDX_W-1:0]  item_idx_q;

	// Cursor and sweep
	logic [COL_W-1:0]   col_q, col_d;
	logic [ROW_W-1:0]   row_q, row_d;
	logic [CELL_AW-1:0] sweep_q;
	logic               scrolled_q;

	// Scroll copy pipeline
	logic               copy_vld_s1;
	logic [CELL_AW-1:0] copy_addr_s1;

	// Result register
	logic               out_vld_q;
	logic [POS_W-1:0]   out_pos_q;
	logic [COLF_W-1:0]  out_col_q;
	logic [ROWF_W-1:0]  out_row_q;
	logic [WORD_W-1:0]  out_word_q;
	logic               out_scr_q;

	// Memory ports
	logic               ram_we;
	logic [CELL_AW-1:0] ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [CELL_AW-1:0] ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;

	logic [COL_W:0]     col_inc;
	logic [ROW_W:0]     row_inc;
	logic               is_newline;
	logic               row_adv;
	logic               row_over;
	logic               put_wr;
	logic               bs_wr;
	logic [CELL_AW-1:0] pos_cur;
	logic [CELL_AW-1:0] pos_nxt;
	logic [WORD_W-1:0]  blank_cell;

	assign col_inc    = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
	assign is_newline = (item_char_q == NEWLINE_CODE);
	assign row_adv    = is_newline || (col_inc == (COL_W+1)'(COLUMNS));
	assign row_over   = row_adv && (row_inc == (ROW_W+1)'(ROWS));
	assign put_wr     = cmd.exec && (item_cmd_q == CMD_PUT) && !is_newline;
	assign bs_wr      = cmd.exec && (item_cmd_q == CMD_BACKSPACE);
	assign blank_cell = {blank_attr, BLANK_CHAR};

	assign pos_cur = CELL_AW'(row_q) * CELL_AW'(COLUMNS) + CELL_AW'(col_q);
	assign pos_nxt = CELL_AW'(row_d) * CELL_AW'(COLUMNS) + CELL_AW'(col_d);

	// Cursor after the executing command
	always_comb begin
		col_d = col_q;
		row_d = row_q;
		if (cmd.exec) begin
			unique case (item_cmd_q)
				CMD_PUT: begin
					if (row_adv) begin
						col_d = '0;
						row_d = row_over ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
					end else begin
						col_d = col_inc[COL_W-1:0];
					end
				end
				CMD_BACKSPACE: begin
					if (col_q != '0) begin
						col_d = col_q - COL_W'(1);
					end else if (row_q != '0) begin
						row_d = row_q - ROW_W'(1);
						col_d = COL_W'(COLUMNS - 1);
					end
				end
				CMD_CLEAR: begin
					col_d = '0;
					row_d = '0;
				end
				CMD_READ: begin
					col_d = col_q;
					row_d = row_q;
				end
				default: begin
					col_d = col_q;
					row_d = row_q;
				end
			endcase
		end
	end

	// Write port: a pending scroll copy never meets another write
	always_comb begin
		ram_we    = 1'b1;
		ram_waddr = sweep_q;
		ram_wdata = CLEAR_CELL;
		priority if (copy_vld_s1) begin
			ram_waddr = copy_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.fill_wr) begin
			ram_waddr = sweep_q;
			ram_wdata = CLEAR_CELL;
		end else if (cmd.blank_wr) begin
			ram_waddr = sweep_q;
			ram_wdata = blank_cell;
		end else if (put_wr) begin
			ram_waddr = pos_cur;
			ram_wdata = {item_color_q, item_char_q};
		end else if (bs_wr) begin
			ram_waddr = pos_nxt;
			ram_wdata = blank_cell;
		end else begin
			ram_we = 1'b0;
		end
	end

	assign ram_raddr = cmd.copy_rd ? (sweep_q + CELL_AW'(COLUMNS)) : CELL_AW'(item_idx_q);

	tcw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			item_cmd_q   <= cmd_t'(in_cmd);
			item_char_q  <= in_char_code;
			item_color_q <= in_color;
			item_idx_q   <= in_cell_index;
		end
		copy_addr_s1 <= sweep_q;
		if (cmd.out_load) begin
			out_pos_q  <= POS_W'(pos_nxt);
			out_col_q  <= COLF_W'(col_d);
			out_row_q  <= ROWF_W'(row_d);
			out_word_q <= cmd.word_sel ? ram_rdata : '0;
			out_scr_q  <= cmd.exec ? (put_wr || (item_cmd_q == CMD_PUT)) && row_over
			                       : scrolled_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			sweep_q     <= '0;
			scrolled_q  <= 1'b0;
			copy_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			col_q       <= col_d;
			row_q       <= row_d;
			copy_vld_s1 <= cmd.copy_rd;
			if (cmd.exec) begin
				scrolled_q <= (item_cmd_q == CMD_PUT) && row_over;
			end
			priority if (cmd.sweep_clr) begin
				sweep_q <= '0;
			end else if (cmd.sweep_blank) begin
				sweep_q <= CELL_AW'(CELLS - COLUMNS);
			end else if (cmd.sweep_step) begin
				sweep_q <= (sweep_q == CELL_AW'(CELLS - 1)) ? '0 : sweep_q + CELL_AW'(1);
			end
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.item_cmd    = item_cmd_q;
		sts.wrap_scroll = (item_cmd_q == CMD_PUT) && row_over;
		sts.read_hit    = (int'(item_idx_q) < CELLS);
		sts.sweep_last  = (sweep_q == CELL_AW'(CELLS - 1));
		sts.copy_last   = (sweep_q == CELL_AW'(CELLS - COLUMNS - 1));
		sts.out_free    = !out_vld_q || m_tready;
	end

	assign out_valid       = out_vld_q;
	assign cursor_position = out_pos_q;
	assign cursor_column   = out_col_q;
	assign cursor_row      = out_row_q;
	assign cell_word       = out_word_q;
	assign scrolled        = out_scr_q;

	a_copy_write_alone: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> !(cmd.fill_wr || cmd.blank_wr || put_wr || bs_wr))
		else $error("scroll copy write collides with another store write");

	a_result_not_overwritten: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_vld_q || m_tready))
		else $error("result register loaded while a beat still waits");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
		else $error("cursor left the screen");

	a_copy_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.copy_rd |-> (int'(sweep_q) < CELLS - COLUMNS))
		else $error("scroll copy reads beyond the store");

endmodule
